/* design/assert_macros.svh */
// Assertion macros shared by the checker files of the pixel encoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a consequence a fixed number of cycles after a condition holds.
`define LGPE_AFTER(name, lat, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(lat) (cons)) \
    else $error("pixel encoder: delayed check failed");

// Check a consequence in the cycle after a condition holds.
`define LGPE_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pixel encoder: next-cycle check failed");

`endif

/* design/lgpe_pkg.sv */
// Shared types, constants and table builder of the linear-to-gamma pixel encoder.
package lgpe_pkg;

  localparam int IN_W          = 16;
  localparam int MAG_W         = IN_W - 1;
  localparam int CODE_W        = 8;
  localparam int CODE_CNT      = 1 << CODE_W;
  localparam int STEPS         = CODE_W;
  localparam int THR_W         = 16;
  localparam int THR_NEVER     = 1 << MAG_W;
  localparam int FRAC_BITS_DEF = 12;

  // Linear segment: x <= 0.0031308, code = floor(x * 12.92 * 256)
  localparam int LIN_THR_NUM   = 31308;
  localparam int LIN_THR_DEN   = 10000000;
  localparam int LIN_NUM       = 330752;
  localparam int LIN_SCALE     = 100;
  localparam int LIN_CODE_W    = 4;
  localparam int LIN_CODE_MAX  = (1 << LIN_CODE_W) - 1;
  localparam int LIN_PROD_W    = 34;

  // Power segment: x^5 * 33760^11 >= (125k + 1760)^11
  localparam int POW_DEN       = 33760;
  localparam int POW_STEP      = 125;
  localparam int POW_OFS       = 1760;
  localparam int POW_OUT_EXP   = 11;
  localparam int POW_IN_EXP    = 5;
  localparam int BIG_W         = 288;

  // Accepting edge to the edge that takes the result strobe
  localparam int LATENCY       = STEPS + 2;

  typedef logic [CODE_CNT-1:0][THR_W-1:0] thr_tab_t;

  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
  } lane_res_t;

  function automatic logic [BIG_W-1:0] big_pow(input logic [BIG_W-1:0] b, input int e);
    logic [BIG_W-1:0] r;
    r = BIG_W'(1);
    for (int i = 0; i < e; i++) begin
      r = r * b;
    end
    return r;
  endfunction

  // Smallest magnitude that reaches each code on the power curve; THR_NEVER if none.
  function automatic thr_tab_t build_thr_tab(input int frac);
    logic [BIG_W-1:0] c_den;
    logic [BIG_W-1:0] rhs;
    logic [BIG_W-1:0] lhs;
    int unsigned      lo;
    int unsigned      hi;
    int unsigned      mid;
    thr_tab_t         tab;
    c_den = big_pow(BIG_W'(POW_DEN), POW_OUT_EXP);
    for (int k = 0; k < CODE_CNT; k++) begin
      rhs = big_pow(BIG_W'(POW_STEP * k + POW_OFS), POW_OUT_EXP) << (POW_IN_EXP * frac);
      lo  = 1;
      hi  = THR_NEVER;
      for (int i = 0; i <= MAG_W; i++) begin
        if (lo < hi) begin
          mid = (lo + hi) >> 1;
          lhs = big_pow(BIG_W'(mid), POW_IN_EXP) * c_den;
          if (lhs >= rhs) begin
            hi = mid;
          end else begin
            lo = mid + 1;
          end
        end
      end
      tab[k] = THR_W'(lo);
    end
    return tab;
  endfunction

endpackage

/* design/lgpe_lane.sv */
// One channel lane: linear-segment code plus an 8-step threshold search on the power curve.
module lgpe_lane
  import lgpe_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic signed [IN_W-1:0] in_raw,
  output lane_res_t              res
);

  localparam thr_tab_t ThrTab = build_thr_tab(FRAC_BITS);
  localparam int       LinMax = (LIN_THR_NUM << FRAC_BITS) / LIN_THR_DEN;
  localparam int       LinDiv = LIN_SCALE << FRAC_BITS;

  logic [MAG_W-1:0]      mag_nxt;
  logic [LIN_PROD_W-1:0] lin_prod;
  logic [LIN_CODE_W-1:0] linc_nxt;
  logic                  linf_nxt;
  logic [CODE_W-1:0]     cand;
  logic [CODE_W-1:0]     acc_nxt [1:STEPS];

  logic                  vld_r  [0:STEPS];
  logic [MAG_W-1:0]      mag_r  [0:STEPS];
  logic [CODE_W-1:0]     acc_r  [0:STEPS];
  logic                  linf_r [0:STEPS];
  logic [LIN_CODE_W-1:0] linc_r [0:STEPS];

  // Drop negative input to zero, work out the linear-segment code
  always_comb begin
    mag_nxt  = in_raw[IN_W-1] ? '0 : in_raw[MAG_W-1:0];
    lin_prod = LIN_PROD_W'(mag_nxt) * LIN_PROD_W'(LIN_NUM);
    linf_nxt = (mag_nxt <= MAG_W'(LinMax));
    linc_nxt = '0;
    for (int c = 1; c <= LIN_CODE_MAX; c++) begin
      if (lin_prod >= LIN_PROD_W'(c * LinDiv)) begin
        linc_nxt = LIN_CODE_W'(c);
      end
    end
  end

  // Decide one code bit per step, MSB first
  always_comb begin
    cand = '0;
    for (int s = 0; s < STEPS; s++) begin
      cand           = acc_r[s] | (CODE_W'(1) << (STEPS - 1 - s));
      acc_nxt[s + 1] = ({1'b0, mag_r[s]} >= ThrTab[cand]) ? cand : acc_r[s];
    end
  end

  // Advance request valid through the steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= STEPS; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else begin
      vld_r[0] <= in_valid;
      for (int s = 0; s < STEPS; s++) begin
        vld_r[s + 1] <= vld_r[s];
      end
    end
  end

  // Advance payload through the steps
  always_ff @(posedge clk) begin
    mag_r[0]  <= mag_nxt;
    acc_r[0]  <= '0;
    linf_r[0] <= linf_nxt;
    linc_r[0] <= linc_nxt;
    for (int s = 0; s < STEPS; s++) begin
      mag_r[s + 1]  <= mag_r[s];
      acc_r[s + 1]  <= acc_nxt[s + 1];
      linf_r[s + 1] <= linf_r[s];
      linc_r[s + 1] <= linc_r[s];
    end
  end

  // Pick the segment that applies
  always_comb begin
    res.valid = vld_r[STEPS];
    res.code  = linf_r[STEPS] ? CODE_W'(linc_r[STEPS]) : acc_r[STEPS];
  end

endmodule

/* design/lgpe_merge.sv */
// Merge stage: joins the three lane results into one registered pixel result.
module lgpe_merge
  import lgpe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  lane_res_t         red,
  input  lane_res_t         green,
  input  lane_res_t         blue,
  output logic              out_valid,
  output logic [CODE_W-1:0] out_red_code,
  output logic [CODE_W-1:0] out_green_code,
  output logic [CODE_W-1:0] out_blue_code
);

  logic              valid_nxt;
  logic              valid_r;
  logic [CODE_W-1:0] red_r;
  logic [CODE_W-1:0] green_r;
  logic [CODE_W-1:0] blue_r;

  // Lanes run in lockstep, so all three valids agree
  assign valid_nxt = red.valid & green.valid & blue.valid;

  // Hold the strobe for one cycle per request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Register the codes
  always_ff @(posedge clk) begin
    red_r   <= red.code;
    green_r <= green.code;
    blue_r  <= blue.code;
  end

  assign out_valid      = valid_r;
  assign out_red_code   = red_r;
  assign out_green_code = green_r;
  assign out_blue_code  = blue_r;

endmodule

/* design/linear_to_gamma_pixel_encoder.sv */
// Top level: three channel lanes side by side feeding one merge stage.
// A request passes the lane step registers, then the merge register, before out_valid rises.
// Throughput: one pixel per clock while busy is low; start is held off only by reset, through the busy register.
// The 8-step code search is pipelined, one threshold table lookup per step and register stage.
// Reset: synchronous, active low; clears the valid pipeline and holds busy high.
module linear_to_gamma_pixel_encoder
  import lgpe_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [IN_W-1:0] in_red_linear,
  input  logic signed [IN_W-1:0] in_green_linear,
  input  logic signed [IN_W-1:0] in_blue_linear,
  output logic                   out_valid,
  output logic [CODE_W-1:0]      out_red_code,
  output logic [CODE_W-1:0]      out_green_code,
  output logic [CODE_W-1:0]      out_blue_code
);

  logic      busy_r;
  logic      accept;
  lane_res_t red_res;
  lane_res_t green_res;
  lane_res_t blue_res;

  // Register busy: set while in reset, cleared once reset is seen released
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start & ~busy_r;

  lgpe_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_red (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .in_raw   (in_red_linear),
    .res      (red_res)
  );

  lgpe_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_green (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .in_raw   (in_green_linear),
    .res      (green_res)
  );

  lgpe_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_blue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .in_raw   (in_blue_linear),
    .res      (blue_res)
  );

  lgpe_merge u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .red            (red_res),
    .green          (green_res),
    .blue           (blue_res),
    .out_valid      (out_valid),
    .out_red_code   (out_red_code),
    .out_green_code (out_green_code),
    .out_blue_code  (out_blue_code)
  );

endmodule

/* design/lgpe_checker.sv */
// Port-level checker for the pixel encoder and its bind to the top level.
`include "assert_macros.svh"

module lgpe_checker
  import lgpe_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   start,
  input logic                   busy,
  input logic signed [IN_W-1:0] in_red_linear,
  input logic                   out_valid,
  input logic [CODE_W-1:0]      out_red_code
);

  // Every request gives exactly one result, and no result comes without a request
  `LGPE_AFTER(a_result_follows, LATENCY, start && !busy, out_valid)
  `LGPE_AFTER(a_no_extra_result, LATENCY, !(start && !busy), !out_valid)
  // Negative red intensity encodes to black
  `LGPE_AFTER(a_neg_red_black, LATENCY, start && !busy && in_red_linear[IN_W-1], out_red_code == '0)
  // Requests are taken right after reset
  `LGPE_NEXT(a_ready_after_reset, $rose(rst_n), !busy)

endmodule

bind linear_to_gamma_pixel_encoder lgpe_checker u_lgpe_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_red_linear (in_red_linear),
  .out_valid     (out_valid),
  .out_red_code  (out_red_code)
);
